[hw/rtl/hgwc_pkg.sv]
// Package for the hand gesture window classifier.
// Holds the word types, register and gesture codes, and the controller/datapath
// command and status types. Depends on nothing.
package hgwc_pkg;

  // Number of past frames kept in the flag window.
  localparam int WINDOW_FRAMES = 16;
  localparam int WIN_IDX_W     = $clog2(WINDOW_FRAMES);
  localparam int CNT_W         = $clog2(WINDOW_FRAMES + 1);

  // A forward tap needs more than this many forward-tap flags in the window.
  localparam int TAP_COUNT_NEEDED = 2;

  // Configuration port geometry.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_LETGO_THR  = 2'd0,
    REG_GRAB_THR   = 2'd1,
    REG_STILL_THR  = 2'd2,
    REG_MIN_MOTION = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    GEST_NONE  = 2'd0,
    GEST_TAP   = 2'd1,
    GEST_GRAB  = 2'd2,
    GEST_LETGO = 2'd3
  } gesture_t;

  typedef struct packed {
    logic signed [15:0] hand1_radial_velocity;
    logic signed [15:0] hand2_radial_velocity;
    logic        [15:0] hand1_speed;
    logic        [15:0] hand2_speed;
  } in_word_t;

  typedef struct packed {
    gesture_t gesture;
    logic     tap_marked;
  } out_word_t;

  typedef struct packed {
    logic [14:0] letgo_threshold;
    logic [14:0] grab_threshold;
    logic [15:0] still_threshold;
    logic [4:0]  min_motion_count;
  } cfg_t;

  // One window entry.
  typedef struct packed {
    logic grab;
    logic letgo;
    logic tap_fwd;
    logic tap_seen;
  } flags_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_DECIDE = 2'd2
  } state_t;

  typedef struct packed {
    logic                 load;      // register frame flags derived from the word, clear counts
    logic                 acc;       // add window entry at scan_idx to the counts
    logic [WIN_IDX_W-1:0] scan_idx;
    logic                 commit;    // decide, write window, load output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_blocked;               // output register holds a word not yet taken
  } dp_status_t;

endpackage

[hw/rtl/hand_gesture_window_classifier.sv]
// Top level of the hand gesture window classifier: configuration registers,
// controller and datapath. Depends on hgwc_pkg, hgwc_ctrl and hgwc_dp.
//
//   Channel   Handshake               Word
//   ------    ---------------------   ----------------------------------------
//   input     in_valid / in_ready     in_data  (in_word_t: two velocities, speeds)
//   result    out_valid / out_ready   out_data (out_word_t: gesture, tap_marked)
//   config    psel/penable/pwrite     paddr, pwdata, prdata; pready tied high
//
// Each word passes a capture step that derives the frame flags, a walk of
// the flag window that adds each entry in turn into the shared counters, and a
// decide step that writes the window. Reset (rst_n, synchronous) clears the
// window, its write position and the registers to their defaults. A result
// that waits in the output register does not stop the next word from being
// accepted; only the decide step waits.
module hand_gesture_window_classifier import hgwc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // Configuration registers. The word address is paddr[3:2]; the low bits are
  // byte offsets and are ignored.
  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.letgo_threshold  <= 15'd256;
      cfg_r.grab_threshold   <= 15'd256;
      cfg_r.still_threshold  <= 16'd64;
      cfg_r.min_motion_count <= 5'd3;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LETGO_THR:  cfg_r.letgo_threshold  <= pwdata[14:0];
        REG_GRAB_THR:   cfg_r.grab_threshold   <= pwdata[14:0];
        REG_STILL_THR:  cfg_r.still_threshold  <= pwdata[15:0];
        REG_MIN_MOTION: cfg_r.min_motion_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LETGO_THR:  prdata = {17'd0, cfg_r.letgo_threshold};
      REG_GRAB_THR:   prdata = {17'd0, cfg_r.grab_threshold};
      REG_STILL_THR:  prdata = {16'd0, cfg_r.still_threshold};
      REG_MIN_MOTION: prdata = {27'd0, cfg_r.min_motion_count};
      default:        prdata = '0;
    endcase
  end

  // The controller steps the datapath through capture, window walk and decision.
  dp_cmd_t    cmd;
  dp_status_t status;

  hgwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hgwc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // Once a word is taken, no other is taken until its window walk is done.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is in progress");

  // A decision never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid && !out_ready))
    else $error("output register overwritten before it was taken");

  // A marked tap always yields some gesture.
  a_mark_has_gesture: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.tap_marked) |-> (out_data.gesture != GEST_NONE))
    else $error("tap marked but no gesture reported");

  // A reported tap is always a marked tap.
  a_tap_is_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.gesture == GEST_TAP)) |-> out_data.tap_marked)
    else $error("tap reported without tap mark");
`endif

endmodule

[hw/rtl/hgwc_ctrl.sv]
// Controller of the hand gesture window classifier: sequences capture, window
// scan and decision. Depends on hgwc_pkg.
module hgwc_ctrl import hgwc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [WIN_IDX_W-1:0] LAST_IDX = WIN_IDX_W'(WINDOW_FRAMES - 1);

  state_t               state_r, state_nxt;
  logic [WIN_IDX_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.scan_idx = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.acc = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DECIDE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (!status.out_blocked) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/hgwc_dp.sv]
// Datapath of the hand gesture window classifier: frame flags, flag window,
// window counters, decision and output register. Depends on hgwc_pkg.
module hgwc_dp import hgwc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_word_t   in_data,
  input  cfg_t       cfg,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  logic       out_ready,
  output logic       out_valid,
  output out_word_t  out_data
);

  flags_t               win_r [WINDOW_FRAMES];
  logic [WIN_IDX_W-1:0] pos_r;
  logic [CNT_W-1:0]     cnt_grab_r, cnt_letgo_r, cnt_tap_r, cnt_seen_r;
  logic                 grab_now_r, letgo_now_r, tapf_now_r, still_now_r;
  logic                 out_valid_r;
  out_word_t            out_word_r;

  // Frame flags; velocities are widened to 17 bits so the negated threshold fits.
  logic signed [16:0] v1, v2, lg, gr_neg;
  logic               v1_out, v2_out, v1_in, v2_in;

  always_comb begin
    v1     = {in_data.hand1_radial_velocity[15], in_data.hand1_radial_velocity};
    v2     = {in_data.hand2_radial_velocity[15], in_data.hand2_radial_velocity};
    lg     = $signed({2'b00, cfg.letgo_threshold});
    gr_neg = $signed(17'd0 - {2'b00, cfg.grab_threshold});
    v1_out = v1 > lg;
    v2_out = v2 > lg;
    v1_in  = v1 < gr_neg;
    v2_in  = v2 < gr_neg;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      letgo_now_r <= v1_out && v2_out;
      grab_now_r  <= v1_in && v2_in;
      tapf_now_r  <= v1_out && (in_data.hand2_speed < cfg.still_threshold);
      still_now_r <= (in_data.hand1_speed < cfg.still_threshold) &&
                     (in_data.hand2_speed < cfg.still_threshold);
    end
  end

  flags_t entry;
  assign entry = win_r[cmd.scan_idx];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt_grab_r  <= '0;
      cnt_letgo_r <= '0;
      cnt_tap_r   <= '0;
      cnt_seen_r  <= '0;
    end else if (cmd.acc) begin
      cnt_grab_r  <= cnt_grab_r  + CNT_W'(entry.grab);
      cnt_letgo_r <= cnt_letgo_r + CNT_W'(entry.letgo);
      cnt_tap_r   <= cnt_tap_r   + CNT_W'(entry.tap_fwd);
      cnt_seen_r  <= cnt_seen_r  + CNT_W'(entry.tap_seen);
    end
  end

  // Decision: grab outranks let go, both outrank tap.
  logic     tap_hit;
  gesture_t gesture;

  always_comb begin
    tap_hit = still_now_r && (32'(cnt_tap_r) > TAP_COUNT_NEEDED) && (cnt_seen_r == '0);
    priority if (still_now_r && (32'(cnt_grab_r) > 32'(cfg.min_motion_count))) begin
      gesture = GEST_GRAB;
    end else if (32'(cnt_letgo_r) > 32'(cfg.min_motion_count)) begin
      gesture = GEST_LETGO;
    end else if (tap_hit) begin
      gesture = GEST_TAP;
    end else begin
      gesture = GEST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_FRAMES; i++) begin
        win_r[i] <= '0;
      end
      pos_r <= '0;
    end else if (cmd.commit) begin
      win_r[pos_r] <= '{grab: grab_now_r, letgo: letgo_now_r,
                        tap_fwd: tapf_now_r, tap_seen: tap_hit};
      if (pos_r == WIN_IDX_W'(WINDOW_FRAMES - 1)) begin
        pos_r <= '0;
      end else begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_word_r <= '{gesture: gesture, tap_marked: tap_hit};
    end
  end

  assign status.out_blocked = out_valid_r && !out_ready;
  assign out_valid          = out_valid_r;
  assign out_data           = out_word_r;

endmodule

[verif/hgwc_checker.sv]
`timescale 1ns / 100ps
// Checker for the hand gesture window classifier: watches the frame, result and
// register ports, predicts each gesture word and compares. Depends on hgwc_pkg.
module hgwc_checker import hgwc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_word_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_word_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                mismatch_count,
  output int                pending_count
);

  // Shadow of the block's registers and flag window.
  cfg_t        cfg_copy;
  bit          grab_win     [WINDOW_FRAMES];
  bit          letgo_win    [WINDOW_FRAMES];
  bit          tap_fwd_win  [WINDOW_FRAMES];
  bit          tap_seen_win [WINDOW_FRAMES];
  int unsigned wr_pos;
  out_word_t   expected_gestures[$];

  // Classifies one frame against the window, then stores its flags.
  function automatic out_word_t classify_frame(input in_word_t w);
    int          v1, v2, lg, gr;
    bit          letgo_now, grab_now, tap_fwd_now, still_now, tap_hit;
    int unsigned n_grab, n_letgo, n_tap_fwd, n_seen;
    out_word_t   r;
    v1 = $signed(w.hand1_radial_velocity);
    v2 = $signed(w.hand2_radial_velocity);
    lg = int'(cfg_copy.letgo_threshold);
    gr = -int'(cfg_copy.grab_threshold);
    letgo_now   = (v1 > lg) && (v2 > lg);
    grab_now    = (v1 < gr) && (v2 < gr);
    tap_fwd_now = (v1 > lg) && (w.hand2_speed < cfg_copy.still_threshold);
    still_now   = (w.hand1_speed < cfg_copy.still_threshold) &&
                  (w.hand2_speed < cfg_copy.still_threshold);
    n_grab = 0;
    n_letgo = 0;
    n_tap_fwd = 0;
    n_seen = 0;
    for (int i = 0; i < WINDOW_FRAMES; i++) begin
      n_grab    += grab_win[i];
      n_letgo   += letgo_win[i];
      n_tap_fwd += tap_fwd_win[i];
      n_seen    += tap_seen_win[i];
    end
    tap_hit = still_now && (n_tap_fwd > TAP_COUNT_NEEDED) && (n_seen == 0);
    r.gesture = tap_hit ? GEST_TAP : GEST_NONE;
    if (still_now && (n_grab > cfg_copy.min_motion_count)) begin
      r.gesture = GEST_GRAB;
    end else if (n_letgo > cfg_copy.min_motion_count) begin
      r.gesture = GEST_LETGO;
    end
    r.tap_marked = tap_hit;
    grab_win[wr_pos]     = grab_now;
    letgo_win[wr_pos]    = letgo_now;
    tap_fwd_win[wr_pos]  = tap_fwd_now;
    tap_seen_win[wr_pos] = tap_hit;
    wr_pos = (wr_pos + 1) % WINDOW_FRAMES;
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      cfg_copy.letgo_threshold  = 15'd256;
      cfg_copy.grab_threshold   = 15'd256;
      cfg_copy.still_threshold  = 16'd64;
      cfg_copy.min_motion_count = 5'd3;
      for (int i = 0; i < WINDOW_FRAMES; i++) begin
        grab_win[i]     = 1'b0;
        letgo_win[i]    = 1'b0;
        tap_fwd_win[i]  = 1'b0;
        tap_seen_win[i] = 1'b0;
      end
      wr_pos = 0;
      expected_gestures.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_AW-1:2]))
          REG_LETGO_THR:  cfg_copy.letgo_threshold  = pwdata[14:0];
          REG_GRAB_THR:   cfg_copy.grab_threshold   = pwdata[14:0];
          REG_STILL_THR:  cfg_copy.still_threshold  = pwdata[15:0];
          REG_MIN_MOTION: cfg_copy.min_motion_count = pwdata[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_gestures.push_back(classify_frame(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_gestures.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word, gesture %0d tap_marked %0b", $time,
                   out_data.gesture, out_data.tap_marked);
        end else begin
          want = expected_gestures.pop_front();
          if (out_data.gesture !== want.gesture) begin
            mismatch_count++;
            $display("%0t: gesture expected %0d actual %0d", $time, want.gesture,
                     out_data.gesture);
          end
          if (out_data.tap_marked !== want.tap_marked) begin
            mismatch_count++;
            $display("%0t: tap_marked expected %0b actual %0b", $time,
                     want.tap_marked, out_data.tap_marked);
          end
        end
      end
    end
    pending_count = expected_gestures.size();
  end

endmodule

[verif/tb_hand_gesture_window_classifier.sv]
`timescale 1ns / 100ps
// Testbench top for the hand gesture window classifier: clock, reset, frame
// stimulus, register writes and the verdict. Depends on hgwc_pkg, the block and
// hgwc_checker.
module tb_hand_gesture_window_classifier;
  import hgwc_pkg::*;

  typedef enum int {FR_NOISE, FR_LETGO, FR_GRAB, FR_TAPF, FR_STILL} frame_kind_t;

  // Ten register settings of about 125 frames each give the run its length.
  localparam int PHASE_COUNT     = 10;
  localparam int WORDS_PER_PHASE = 125;
  // A word is captured, walked through the window and decided; wait longer than that.
  localparam int SETTLE_CYCLES   = WINDOW_FRAMES + 6;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_word_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int mismatches;
  int pending;

  // Percent chances of the sender idling and the receiver stalling per cycle.
  int idle_pct = 0;
  int stall_pct = 0;

  // The settings last written, used only to aim the frame values at the
  // thresholds; prediction keeps its own copy in the checker.
  int letgo_thr = 256;
  int grab_thr = 256;
  int still_thr = 64;

  hand_gesture_window_classifier u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  hgwc_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatches),
    .pending_count  (pending)
  );

  always #5 clk = ~clk;

  // The receiver decides afresh at every edge whether it takes a word.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("tb_hand_gesture_window_classifier: errors");
    $finish;
  end

  // A velocity strictly above thr. When thr is the largest positive value no
  // such velocity exists, so the largest one is given and fails the test.
  function automatic logic [15:0] above_thr(input int thr);
    if (thr >= 32767) return 16'h7fff;
    if ($urandom_range(3) == 0) return 16'(thr + 1);
    return 16'(thr + 1 + int'($urandom_range(32766 - thr)));
  endfunction

  // A velocity strictly below -thr; always exists since thr is at most 32767.
  function automatic logic [15:0] below_neg(input int thr);
    int limit;
    limit = -thr - 1;
    if ($urandom_range(3) == 0) return 16'(limit);
    return 16'(-32768 + int'($urandom_range(limit + 32768)));
  endfunction

  // A speed strictly below thr, or zero when none exists.
  function automatic logic [15:0] below_speed(input int thr);
    if (thr == 0) return 16'h0000;
    if ($urandom_range(3) == 0) return 16'(thr - 1);
    return 16'($urandom_range(thr - 1));
  endfunction

  // Velocities right on and next to the thresholds, and the extremes, so
  // that the strict comparisons are hit from both sides.
  function automatic logic [15:0] near_thr_vel();
    case ($urandom_range(6))
      0: return 16'(letgo_thr);
      1: return above_thr(letgo_thr);
      2: return 16'(-grab_thr);
      3: return below_neg(grab_thr);
      4: return 16'h7fff;
      5: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] near_thr_speed();
    case ($urandom_range(4))
      0: return 16'(still_thr);
      1: return below_speed(still_thr);
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Builds a frame aimed at one per-frame flag; every field not aimed stays
  // fully random, so all bits of all fields see both values.
  function automatic in_word_t make_frame(input frame_kind_t kind);
    in_word_t w;
    w.hand1_radial_velocity = 16'($urandom);
    w.hand2_radial_velocity = 16'($urandom);
    w.hand1_speed           = 16'($urandom);
    w.hand2_speed           = 16'($urandom);
    case (kind)
      FR_NOISE: begin
        if ($urandom_range(1) == 0) begin
          w.hand1_radial_velocity = near_thr_vel();
          w.hand2_radial_velocity = near_thr_vel();
          w.hand1_speed           = near_thr_speed();
          w.hand2_speed           = near_thr_speed();
        end
      end
      FR_LETGO: begin
        w.hand1_radial_velocity = above_thr(letgo_thr);
        w.hand2_radial_velocity = above_thr(letgo_thr);
      end
      FR_GRAB: begin
        w.hand1_radial_velocity = below_neg(grab_thr);
        w.hand2_radial_velocity = below_neg(grab_thr);
        // Half the grab frames are also still, which a grab report needs.
        if ($urandom_range(1) == 0) begin
          w.hand1_speed = below_speed(still_thr);
          w.hand2_speed = below_speed(still_thr);
        end
      end
      FR_TAPF: begin
        w.hand1_radial_velocity = above_thr(letgo_thr);
        w.hand2_speed           = below_speed(still_thr);
      end
      default: begin
        w.hand1_speed = below_speed(still_thr);
        w.hand2_speed = below_speed(still_thr);
      end
    endcase
    return w;
  endfunction

  function automatic in_word_t frame_of(input int v1, input int v2, input int s1,
                                        input int s2);
    in_word_t w;
    w.hand1_radial_velocity = 16'(v1);
    w.hand2_radial_velocity = 16'(v2);
    w.hand1_speed           = 16'(s1);
    w.hand2_speed           = 16'(s2);
    return w;
  endfunction

  // Offers one word and returns right after the edge that accepts it. Valid
  // is only dropped during an idle gap and stays high from word to word.
  task automatic send_frame(input in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits until every predicted word has come back and the block has had
  // time to finish its last decide step.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle. The bits above the
  // register width carry junk, which the block must drop.
  task automatic write_reg(input reg_idx_t idx, input int unsigned value,
                           input int unsigned mask);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~mask) | (value & mask);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input int lg, input int gr, input int st, input int mm);
    drain();
    write_reg(REG_LETGO_THR, lg, 32'h7fff);
    write_reg(REG_GRAB_THR, gr, 32'h7fff);
    write_reg(REG_STILL_THR, st, 32'hffff);
    write_reg(REG_MIN_MOTION, mm, 32'h1f);
    letgo_thr = lg & 32'h7fff;
    grab_thr  = gr & 32'h7fff;
    still_thr = st & 32'hffff;
  endtask

  // Mostly bursts of one kind of motion followed by still frames, which is
  // what fills the window far enough for tap, grab and let-go reports; noise
  // frames are mixed in and stand alone as well.
  task automatic run_random(input int quota);
    int          sent;
    frame_kind_t kind;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(9) < 7) begin
        case ($urandom_range(2))
          0: kind = FR_LETGO;
          1: kind = FR_GRAB;
          default: kind = FR_TAPF;
        endcase
        repeat ($urandom_range(1, 7)) begin
          send_frame(make_frame(($urandom_range(7) == 0) ? FR_NOISE : kind));
          sent++;
        end
        repeat ($urandom_range(3)) begin
          send_frame(make_frame(FR_STILL));
          sent++;
        end
      end else begin
        send_frame(make_frame(($urandom_range(1) == 0) ? FR_NOISE : FR_STILL));
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset settings: extremes of every field, the
    // thresholds exactly and one step past them, then a forward tap, a tap
    // blocked by the tap already seen, a grab and a let-go.
    send_frame(frame_of(0, 0, 0, 0));
    send_frame(frame_of(32767, 32767, 16'hffff, 16'hffff));
    send_frame(frame_of(-32768, -32768, 0, 0));
    send_frame(frame_of(256, 256, 64, 64));
    send_frame(frame_of(257, 257, 63, 63));
    send_frame(frame_of(-256, -256, 63, 63));
    send_frame(frame_of(-257, -257, 63, 63));
    repeat (3) send_frame(frame_of(300, 0, 500, 10));
    send_frame(frame_of(0, 0, 10, 10));
    send_frame(frame_of(0, 0, 10, 10));
    repeat (2) send_frame(frame_of(-1000, -1000, 500, 500));
    send_frame(frame_of(0, 0, 10, 10));
    repeat (2) send_frame(frame_of(1000, 1000, 500, 500));
    send_frame(frame_of(5, -5, 900, 900));
    send_frame(frame_of(-1, 1, 16'h8000, 16'h7fff));
    run_random(WORDS_PER_PHASE - 20);

    for (int p = 1; p < PHASE_COUNT; p++) begin
      drain();
      // Rotate through no idling, a slow sender, a slow receiver and both.
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      case (p)
        // Lowest thresholds: every motion counts and a single flag decides.
        1: apply_setting(0, 0, 16'hffff, 0);
        // Highest: only -32768 passes the grab test, nothing is still, no count is exceeded.
        2: apply_setting(32767, 32767, 0, 31);
        // A motion count equal to the window length can never be exceeded.
        3: apply_setting(100, 5000, 2000, WINDOW_FRAMES);
        4: apply_setting(256, 256, 64, 3);
        default: apply_setting($urandom_range(3000), $urandom_range(3000),
                               $urandom_range(1, 6000), $urandom_range(5));
      endcase
      run_random(WORDS_PER_PHASE);
    end

    drain();
    if (mismatches == 0) begin
      $display("tb_hand_gesture_window_classifier: clean");
    end else begin
      $display("tb_hand_gesture_window_classifier: errors");
    end
    $finish;
  end

endmodule
